// ----- src/o1cx_pkg.sv -----
// Shared types and constants for the order-1 context XOR predictor.
// Holds controller state encoding and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package o1cx_pkg;

	// Model geometry
	localparam int CTX_COUNT      = 256;
	localparam int SYM_W          = 8;
	localparam int ADDR_W         = 2 * SYM_W;
	localparam int SWEEP_W        = SYM_W + 1;
	localparam int COUNT_BITS_DEF = 16;
	localparam int THRESH_W       = 16;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd60000;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD1,
		ST_CLR,
		ST_RD2,
		ST_UPD,
		ST_HALVE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic               accept;    // latch input beat
		logic               rd_req;    // read best[ctx] and count[ctx,sym]
		logic               rd_best;   // read count[ctx,best]
		logic               emit;      // load output register
		logic               upd;       // write back count and best
		logic               clr_wr;    // row clear write
		logic               clr_best;  // zero best[ctx]
		logic               set_valid; // mark row initialized
		logic               hv_rd;     // halving sweep read
		logic               hv_wr;     // halving sweep write
		logic [SWEEP_W-1:0] idx;       // sweep position
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic row_valid;  // current context row initialized in this block
		logic out_free;   // output register can take a beat
		logic halve_req;  // updated count above threshold
	} sts_t;

endpackage

// ----- src/o1cx_ctrl.sv -----
// Controller state machine for the order-1 context XOR predictor.
// Sequences reads, write-back, row clear and row halving sweeps.
// Depends on o1cx_pkg.
`timescale 1ns / 1ps

module o1cx_ctrl
	import o1cx_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t             state_q, state_d;
	logic [SWEEP_W-1:0] idx_q, idx_d;

	// State and sweep counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		idx_d    = '0;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.idx  = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_RD1;
				end
			end
			ST_RD1: begin
				if (sts.row_valid) begin
					cmd.rd_req = 1'b1;
					state_d    = ST_RD2;
				end else begin
					state_d = ST_CLR;
				end
			end
			ST_CLR: begin
				cmd.clr_wr   = 1'b1;
				cmd.clr_best = (idx_q == '0);
				if (idx_q[SYM_W-1:0] == {SYM_W{1'b1}}) begin
					cmd.set_valid = 1'b1;
					state_d       = ST_RD1;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_RD2: begin
				cmd.rd_best = 1'b1;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				if (sts.halve_req) begin
					state_d = ST_HALVE;
				end else begin
					// next beat may enter right behind the write-back
					in_ready = 1'b1;
					if (in_valid) begin
						cmd.accept = 1'b1;
						state_d    = ST_RD1;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_HALVE: begin
				cmd.hv_rd = !idx_q[SWEEP_W-1];
				cmd.hv_wr = (idx_q != '0);
				if (idx_q[SWEEP_W-1]) begin
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/o1cx_dpath.sv -----
// Datapath for the order-1 context XOR predictor: count and best-symbol
// memories, row-valid bits, threshold register and output register.
// Depends on o1cx_pkg; driven by o1cx_ctrl.
`timescale 1ns / 1ps

module o1cx_dpath
	import o1cx_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [SYM_W-1:0]    data_byte,
	input  logic                first_of_block,
	input  logic                cfg_we,
	input  logic [THRESH_W-1:0] cfg_wdata,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SYM_W-1:0]    residual_byte,
	output logic [SYM_W-1:0]    pred_byte
);

	localparam int CMP_W = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Storage
	logic [COUNT_BITS-1:0] cnt_mem  [CTX_COUNT*CTX_COUNT];
	logic [SYM_W-1:0]      best_mem [CTX_COUNT];

	logic [SYM_W-1:0]      prev_q, ctx_q, sym_q, best_q;
	logic [THRESH_W-1:0]   thr_q;
	logic [CTX_COUNT-1:0]  valid_q;
	logic [COUNT_BITS-1:0] rda_q, rdb_q;
	logic                  out_valid_q;
	logic [SYM_W-1:0]      res_q, pred_q;

	logic [COUNT_BITS-1:0] cnt_new;
	logic                  better;
	logic [SWEEP_W-1:0]    idx_m1;
	logic [ADDR_W-1:0]     wr_addr, rda_addr;
	logic [COUNT_BITS-1:0] wr_data;
	logic                  wr_en;

	// Saturating increment and compares
	assign cnt_new = (rda_q == COUNT_MAX) ? rda_q : rda_q + 1'b1;
	assign better  = cnt_new > rdb_q;
	assign idx_m1  = cmd.idx - 1'b1;

	assign sts.row_valid = valid_q[ctx_q];
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.halve_req = CMP_W'(cnt_new) > CMP_W'(thr_q);

	// Control registers: previous byte, threshold, row-valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			thr_q   <= THRESH_RESET;
			valid_q <= '0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				prev_q <= data_byte;
				if (first_of_block) begin
					valid_q <= '0;
				end
			end else if (cmd.set_valid) begin
				valid_q[ctx_q] <= 1'b1;
			end
		end
	end

	// Input beat payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sym_q <= data_byte;
			ctx_q <= first_of_block ? '0 : prev_q;
		end
	end

	// Count memory write mux
	always_comb begin
		wr_en   = 1'b1;
		wr_addr = {ctx_q, sym_q};
		wr_data = cnt_new;
		priority if (cmd.clr_wr) begin
			wr_addr = {ctx_q, cmd.idx[SYM_W-1:0]};
			wr_data = '0;
		end else if (cmd.hv_wr) begin
			wr_addr = {ctx_q, idx_m1[SYM_W-1:0]};
			wr_data = rda_q >> 1;
		end else if (cmd.upd) begin
			wr_addr = {ctx_q, sym_q};
			wr_data = cnt_new;
		end else begin
			wr_en = 1'b0;
		end
	end

	assign rda_addr = cmd.hv_rd ? {ctx_q, cmd.idx[SYM_W-1:0]} : {ctx_q, sym_q};

	// Count memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cnt_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_req || cmd.hv_rd) begin
			rda_q <= cnt_mem[rda_addr];
		end
		if (cmd.rd_best) begin
			rdb_q <= cnt_mem[{ctx_q, best_q}];
		end
	end

	// Best-symbol memory
	always_ff @(posedge clk) begin
		if (cmd.clr_best) begin
			best_mem[ctx_q] <= '0;
		end else if (cmd.upd && better) begin
			best_mem[ctx_q] <= sym_q;
		end
		if (cmd.rd_req) begin
			best_q <= best_mem[ctx_q];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q  <= sym_q ^ best_q;
			pred_q <= best_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign residual_byte = res_q;
	assign pred_byte     = pred_q;

endmodule

// ----- src/order1_context_xor_predictor.sv -----
// Usage
// Input channel: in_valid/in_ready with data_byte and first_of_block; a beat
// with first_of_block set starts a new block and uses context zero.
// Output channel: out_valid/out_ready with residual_byte (byte XOR prediction)
// and pred_byte, the predicted byte; one output beat per input beat, in order.
// Config: cfg_we/cfg_wdata writes halve_threshold; write only while idle.
// Sequence: an accepted beat passes ST_RD1 (best-symbol and count reads), then
// ST_RD2 (best-count read and output load, held while the output is stalled).
// Bytes are handled one at a time through the best-symbol read, the dependent
// count read and the count write-back on the single write port; the next byte
// may enter during the write-back. The first byte of a context in a block
// first clears that row and repeats the context check; a count above the
// threshold starts a halving sweep of that row and a return through idle.
// Reset: asynchronous, clears control state, the previous byte, the row
// valid bits and restores the threshold to 60000; no clearing pass is needed.
// A stalled receiver holds the output register; the block still finishes the
// held byte's write-back and may accept one more byte before it waits.
// Depends on o1cx_pkg, o1cx_ctrl and o1cx_dpath.
`timescale 1ns / 1ps

module order1_context_xor_predictor
	import o1cx_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SYM_W-1:0]    data_byte,
	input  logic                first_of_block,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SYM_W-1:0]    residual_byte,
	output logic [SYM_W-1:0]    pred_byte,
	input  logic                cfg_we,
	input  logic [THRESH_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	o1cx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	o1cx_dpath #(
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.data_byte      (data_byte),
		.first_of_block (first_of_block),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.residual_byte  (residual_byte),
		.pred_byte      (pred_byte)
	);

endmodule

// ----- src/o1cx_checker.sv -----
// Port-level checks for the order-1 context XOR predictor, bound to the top.
// Depends on o1cx_pkg and order1_context_xor_predictor.
`timescale 1ns / 1ps

module o1cx_checker
	import o1cx_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [SYM_W-1:0] residual_byte,
	input logic [SYM_W-1:0] pred_byte
);

	// Stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(residual_byte)
			&& $stable(pred_byte))
		else $error("output beat changed while stalled");

	// Each byte passes both read states (ST_RD1, ST_RD2) before the next beat
	a_accept_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input beat accepted too soon");

	// Nothing pending right out of reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind order1_context_xor_predictor o1cx_checker u_o1cx_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.residual_byte (residual_byte),
	.pred_byte     (pred_byte)
);
